>>> sv/heartbeat_pwm_envelope_macros.svh
// assertion macros shared by the heartbeat envelope rtl
`ifndef HEARTBEAT_PWM_ENVELOPE_MACROS_SVH
`define HEARTBEAT_PWM_ENVELOPE_MACROS_SVH

// same-cycle implication, off during reset
`define HPE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define HPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/hpe_pkg.sv
// types, constants and register map of the heartbeat envelope
package hpe_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PEAK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUB_RAMP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUB_RAMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_SLOWEST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_SPAN    = 3'd5;

    localparam logic [15:0] PWM_PEAK_RST     = 16'd249;
    localparam logic [9:0]  LUB_RAMP_RST     = 10'd40;
    localparam logic [9:0]  GAP_RST          = 10'd80;
    localparam logic [9:0]  DUB_RAMP_RST     = 10'd80;
    localparam logic [15:0] REST_SLOWEST_RST = 16'd2000;
    localparam logic [15:0] REST_SPAN_RST    = 16'd1850;

    localparam int SCORE_W = 7;
    localparam int DVS_W   = 10;
    localparam int DIV_W   = 26;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DVS_W-1:0] PCT_DIVISOR = 10'd100;

    typedef enum logic [2:0] {
        PH_LUB_UP   = 3'd0,
        PH_LUB_DOWN = 3'd1,
        PH_GAP      = 3'd2,
        PH_DUB_UP   = 3'd3,
        PH_DUB_DOWN = 3'd4,
        PH_REST     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_CUT,
        S_DIV_CUT,
        S_EVAL,
        S_DIV_RAMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [15:0] pwm_peak;
        logic [9:0]  lub_ramp;
        logic [9:0]  gap;
        logic [9:0]  dub_ramp;
        logic [15:0] rest_slowest;
        logic [15:0] rest_span;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> sv/hpe_in_if.sv
// input channel: time stamp and motion score
interface hpe_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [hpe_pkg::SCORE_W-1:0] motion_score;

    modport source (output valid, output now_ms, output motion_score, input ready);
    modport sink (input valid, input now_ms, input motion_score, output ready);
endinterface

>>> sv/hpe_out_if.sv
// output channel: duty, idle time and rest flag
interface hpe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty;
    logic [15:0] idle_ms;
    logic        rest_entered;

    modport source (output valid, output duty, output idle_ms, output rest_entered,
                    input ready);
    modport sink (input valid, input duty, input idle_ms, input rest_entered,
                  output ready);
endinterface

>>> sv/heartbeat_pwm_envelope.sv
// top level of the heartbeat envelope: phase sequencer around the shared divider
//
// i_in carries now_ms and motion_score; o_out returns one item per input item with
// duty, idle_ms and rest_entered. Both channels move an item when valid and ready
// are high at a rising edge. Configuration is written through i_cfg_we, i_cfg_idx
// and i_cfg_data; the user must write it only while no item is in flight, which the
// block itself leaves unchecked. Each item is handled alone: the rest length needs a
// division by 100 and a ramp step needs a division by the ramp length, both on one
// 26-bit divider that yields one quotient bit per cycle. Every item passes through
// the rest cut and the evaluation; an item inside a ramp also waits for a second
// division before its result.
// i_in.ready is high only while the sequencer waits for an item.
// The result sits in an output register; a new item is accepted while it waits,
// and the sequencer holds at its last step until the receiver frees that register.
// A synchronous reset restores the register defaults, the beat to the start of
// the lub rise with a phase start time of zero, and empties the output register.
`include "heartbeat_pwm_envelope_macros.svh"

module heartbeat_pwm_envelope #(
    parameter int TIME_BITS = hpe_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hpe_in_if.sink                         i_in,
    hpe_out_if.source                      o_out
);

    localparam int DW = hpe_pkg::DIV_W;
    localparam int SW = hpe_pkg::SCORE_W;

    hpe_pkg::t_cfg     cfg;
    hpe_pkg::t_div_req div_req;
    hpe_pkg::t_div_rsp div_rsp;

    hpe_pkg::t_state r_state, n_state;
    hpe_pkg::t_phase r_phase, n_phase;
    hpe_pkg::t_phase r_nphase, n_nphase;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic [31:0]          r_now, n_now;
    logic [SW-1:0]        r_score, n_score;
    logic [15:0]          r_rest, n_rest;
    logic [15:0]          r_duty, n_duty;
    logic [15:0]          r_idle, n_idle;
    logic                 r_entered, n_entered;
    logic                 r_move, n_move;
    logic                 r_out_valid, n_out_valid;
    logic [15:0]          r_o_duty, n_o_duty;
    logic [15:0]          r_o_idle, n_o_idle;
    logic                 r_o_entered, n_o_entered;

    logic [15:0]     len_cur;
    logic [15:0]     target;
    logic [9:0]      ramp_len;
    logic            is_ramp;
    logic            is_up;
    logic            phase_over;
    hpe_pkg::t_phase phase_next;
    logic [15:0]     mul_a;
    logic [9:0]      mul_b;
    logic [DW-1:0]   mul_p;
    logic [15:0]     duty_cl;

    hpe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // phase decode
    always_comb begin
        is_ramp  = (r_phase == hpe_pkg::PH_LUB_UP) || (r_phase == hpe_pkg::PH_LUB_DOWN)
                || (r_phase == hpe_pkg::PH_DUB_UP) || (r_phase == hpe_pkg::PH_DUB_DOWN);
        is_up    = (r_phase == hpe_pkg::PH_LUB_UP) || (r_phase == hpe_pkg::PH_DUB_UP);
        target   = cfg.pwm_peak;
        ramp_len = cfg.dub_ramp;
        if ((r_phase == hpe_pkg::PH_LUB_UP) || (r_phase == hpe_pkg::PH_LUB_DOWN)) begin
            target   = {1'b0, cfg.pwm_peak[15:1]};
            ramp_len = cfg.lub_ramp;
        end
        case (r_phase)
            hpe_pkg::PH_LUB_UP: begin
                len_cur    = 16'(cfg.lub_ramp);
                phase_next = hpe_pkg::PH_LUB_DOWN;
            end
            hpe_pkg::PH_LUB_DOWN: begin
                len_cur    = 16'(cfg.lub_ramp);
                phase_next = hpe_pkg::PH_GAP;
            end
            hpe_pkg::PH_GAP: begin
                len_cur    = 16'(cfg.gap);
                phase_next = hpe_pkg::PH_DUB_UP;
            end
            hpe_pkg::PH_DUB_UP: begin
                len_cur    = 16'(cfg.dub_ramp);
                phase_next = hpe_pkg::PH_DUB_DOWN;
            end
            hpe_pkg::PH_DUB_DOWN: begin
                len_cur    = 16'(cfg.dub_ramp);
                phase_next = hpe_pkg::PH_REST;
            end
            default: begin
                len_cur    = r_rest;
                phase_next = hpe_pkg::PH_LUB_UP;
            end
        endcase
        phase_over = (r_elapsed >= TIME_BITS'(len_cur));
        duty_cl    = (r_duty > cfg.pwm_peak) ? cfg.pwm_peak : r_duty;
    end

    // one multiplier: score times span for the rest cut, elapsed times target on a ramp
    always_comb begin
        if (r_state == hpe_pkg::S_EVAL) begin
            mul_a = target;
            mul_b = r_elapsed[9:0];
        end else begin
            mul_a = cfg.rest_span;
            mul_b = 10'(r_score);
        end
        mul_p = {10'd0, mul_a} * {16'd0, mul_b};
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_nphase    = r_nphase;
        n_start     = r_start;
        n_elapsed   = r_elapsed;
        n_now       = r_now;
        n_score     = r_score;
        n_rest      = r_rest;
        n_duty      = r_duty;
        n_idle      = r_idle;
        n_entered   = r_entered;
        n_move      = r_move;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_duty    = r_o_duty;
        n_o_idle    = r_o_idle;
        n_o_entered = r_o_entered;
        div_req.start    = 1'b0;
        div_req.dividend = mul_p;
        div_req.divisor  = hpe_pkg::PCT_DIVISOR;
        i_in.ready       = 1'b0;

        case (r_state)
            hpe_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_now   = i_in.now_ms;
                    n_score = i_in.motion_score;
                    n_state = hpe_pkg::S_MUL_CUT;
                end
            end
            hpe_pkg::S_MUL_CUT: begin
                n_elapsed     = TIME_BITS'(r_now) - r_start;
                div_req.start = 1'b1;
                n_state       = hpe_pkg::S_DIV_CUT;
            end
            hpe_pkg::S_DIV_CUT: begin
                if (div_rsp.done) begin
                    n_rest  = (div_rsp.quot >= DW'(cfg.rest_slowest))
                            ? 16'd0 : cfg.rest_slowest - div_rsp.quot[15:0];
                    n_state = hpe_pkg::S_EVAL;
                end
            end
            hpe_pkg::S_EVAL: begin
                if (phase_over) begin
                    n_move    = 1'b1;
                    n_nphase  = phase_next;
                    n_duty    = is_up ? target : 16'd0;
                    n_entered = (phase_next == hpe_pkg::PH_REST);
                    // fresh phase, elapsed counts from zero
                    if (phase_next == hpe_pkg::PH_GAP) begin
                        n_idle = 16'(cfg.gap);
                    end else if (phase_next == hpe_pkg::PH_REST) begin
                        n_idle = r_rest;
                    end else begin
                        n_idle = 16'd1;
                    end
                    n_state = hpe_pkg::S_FIN;
                end else begin
                    n_move    = 1'b0;
                    n_nphase  = r_phase;
                    n_entered = 1'b0;
                    if (is_ramp) begin
                        div_req.start   = 1'b1;
                        div_req.divisor = ramp_len;
                        n_idle          = 16'd1;
                        n_state         = hpe_pkg::S_DIV_RAMP;
                    end else begin
                        n_duty  = 16'd0;
                        n_idle  = len_cur - r_elapsed[15:0];
                        n_state = hpe_pkg::S_FIN;
                    end
                end
            end
            hpe_pkg::S_DIV_RAMP: begin
                if (div_rsp.done) begin
                    n_duty  = is_up ? div_rsp.quot[15:0] : target - div_rsp.quot[15:0];
                    n_state = hpe_pkg::S_FIN;
                end
            end
            hpe_pkg::S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_duty    = duty_cl;
                    n_o_idle    = r_idle;
                    n_o_entered = r_entered;
                    if (r_move) begin
                        n_phase = r_nphase;
                        n_start = TIME_BITS'(r_now);
                    end
                    n_state = hpe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hpe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hpe_pkg::PH_LUB_UP;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nphase    <= n_nphase;
        r_elapsed   <= n_elapsed;
        r_now       <= n_now;
        r_score     <= n_score;
        r_rest      <= n_rest;
        r_duty      <= n_duty;
        r_idle      <= n_idle;
        r_entered   <= n_entered;
        r_move      <= n_move;
        r_o_duty    <= n_o_duty;
        r_o_idle    <= n_o_idle;
        r_o_entered <= n_o_entered;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.duty         = r_o_duty;
    assign o_out.idle_ms      = r_o_idle;
    assign o_out.rest_entered = r_o_entered;

    `HPE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `HPE_ASSERT_NOW(a_div_start_free, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `HPE_ASSERT_NOW(a_entered_dark, i_clk, i_rst_n, o_out.valid && o_out.rest_entered, (r_phase == hpe_pkg::PH_REST) && (o_out.duty == 16'd0))
    `HPE_ASSERT_NOW(a_lit_on_ramp, i_clk, i_rst_n, o_out.valid && (o_out.duty != 16'd0), o_out.idle_ms == 16'd1)

endmodule

>>> sv/hpe_cfg.sv
// configuration register bank of the heartbeat envelope
module hpe_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hpe_pkg::t_cfg                  o_cfg
);

    hpe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_peak     <= hpe_pkg::PWM_PEAK_RST;
            r_cfg.lub_ramp     <= hpe_pkg::LUB_RAMP_RST;
            r_cfg.gap          <= hpe_pkg::GAP_RST;
            r_cfg.dub_ramp     <= hpe_pkg::DUB_RAMP_RST;
            r_cfg.rest_slowest <= hpe_pkg::REST_SLOWEST_RST;
            r_cfg.rest_span    <= hpe_pkg::REST_SPAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hpe_pkg::CFG_PWM_PEAK:     r_cfg.pwm_peak     <= i_cfg_data;
                hpe_pkg::CFG_LUB_RAMP:     r_cfg.lub_ramp     <= i_cfg_data[9:0];
                hpe_pkg::CFG_GAP:          r_cfg.gap          <= i_cfg_data[9:0];
                hpe_pkg::CFG_DUB_RAMP:     r_cfg.dub_ramp     <= i_cfg_data[9:0];
                hpe_pkg::CFG_REST_SLOWEST: r_cfg.rest_slowest <= i_cfg_data;
                hpe_pkg::CFG_REST_SPAN:    r_cfg.rest_span    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/hpe_div.sv
// shared restoring divider, one quotient bit per cycle
module hpe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hpe_pkg::t_div_req i_req,
    output hpe_pkg::t_div_rsp o_rsp
);

    localparam int DW = hpe_pkg::DIV_W;
    localparam int VW = hpe_pkg::DVS_W;
    localparam int CW = hpe_pkg::DIV_CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        fits;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> tb/heartbeat_pwm_envelope_test.sv
// testbench of the heartbeat envelope: every result checked against a beat predictor
`timescale 1ns / 100ps

module heartbeat_pwm_envelope_test;

    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        logic [15:0] duty;
        logic [15:0] idle_ms;
        logic        rest_entered;
    } t_beat_result;

    class t_beat_board;
        logic [15:0]     pwm_peak;
        logic [9:0]      lub_ramp;
        logic [9:0]      gap_len;
        logic [9:0]      dub_ramp;
        logic [15:0]     rest_slowest;
        logic [15:0]     rest_span;
        hpe_pkg::t_phase phase;
        hpe_pkg::t_phase seen_before;
        logic [31:0]     phase_start;
        t_beat_result    duty_owed[$];
        int              errors;
        int              matched;
        int              rests;

        function new();
            pwm_peak     = hpe_pkg::PWM_PEAK_RST;
            lub_ramp     = hpe_pkg::LUB_RAMP_RST;
            gap_len      = hpe_pkg::GAP_RST;
            dub_ramp     = hpe_pkg::DUB_RAMP_RST;
            rest_slowest = hpe_pkg::REST_SLOWEST_RST;
            rest_span    = hpe_pkg::REST_SPAN_RST;
            phase        = hpe_pkg::PH_LUB_UP;
            seen_before  = hpe_pkg::PH_LUB_UP;
            phase_start  = '0;
            errors       = 0;
            matched      = 0;
            rests        = 0;
        endfunction

        function void write_reg(logic [hpe_pkg::CFG_IDX_W-1:0] idx,
                                logic [hpe_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                hpe_pkg::CFG_PWM_PEAK:     pwm_peak = value;
                hpe_pkg::CFG_LUB_RAMP:     lub_ramp = value[9:0];
                hpe_pkg::CFG_GAP:          gap_len = value[9:0];
                hpe_pkg::CFG_DUB_RAMP:     dub_ramp = value[9:0];
                hpe_pkg::CFG_REST_SLOWEST: rest_slowest = value;
                hpe_pkg::CFG_REST_SPAN:    rest_span = value;
                default: ;
            endcase
        endfunction

        // only called with el below len, so len is never zero here
        function logic [31:0] ramp_level(logic [31:0] el, logic [15:0] target, logic [9:0] len);
            return (el * 32'(target)) / 32'(len);
        endfunction

        function void log_tick(logic [31:0] now, logic [hpe_pkg::SCORE_W-1:0] score);
            logic [31:0]     elapsed;
            logic [31:0]     cut;
            logic [31:0]     rest;
            logic [31:0]     duty;
            logic [31:0]     len;
            logic [31:0]     idle;
            logic [15:0]     half;
            hpe_pkg::t_phase nxt;
            t_beat_result    r;
            elapsed = now - phase_start;
            cut = (32'(score) * 32'(rest_span)) / 32'd100;
            rest = (cut >= 32'(rest_slowest)) ? 32'd0 : 32'(rest_slowest) - cut;
            half = pwm_peak >> 1;
            duty = '0;
            nxt = phase;
            case (phase)
                hpe_pkg::PH_LUB_UP: begin
                    if (elapsed >= 32'(lub_ramp)) begin
                        nxt = hpe_pkg::PH_LUB_DOWN;
                        duty = 32'(half);
                    end else begin
                        duty = ramp_level(elapsed, half, lub_ramp);
                    end
                end
                hpe_pkg::PH_LUB_DOWN: begin
                    if (elapsed >= 32'(lub_ramp)) begin
                        nxt = hpe_pkg::PH_GAP;
                    end else begin
                        duty = 32'(half) - ramp_level(elapsed, half, lub_ramp);
                    end
                end
                hpe_pkg::PH_GAP: begin
                    if (elapsed >= 32'(gap_len)) nxt = hpe_pkg::PH_DUB_UP;
                end
                hpe_pkg::PH_DUB_UP: begin
                    if (elapsed >= 32'(dub_ramp)) begin
                        nxt = hpe_pkg::PH_DUB_DOWN;
                        duty = 32'(pwm_peak);
                    end else begin
                        duty = ramp_level(elapsed, pwm_peak, dub_ramp);
                    end
                end
                hpe_pkg::PH_DUB_DOWN: begin
                    if (elapsed >= 32'(dub_ramp)) begin
                        nxt = hpe_pkg::PH_REST;
                    end else begin
                        duty = 32'(pwm_peak) - ramp_level(elapsed, pwm_peak, dub_ramp);
                    end
                end
                default: begin
                    if (elapsed >= rest) nxt = hpe_pkg::PH_LUB_UP;
                end
            endcase
            if (duty > 32'(pwm_peak)) duty = 32'(pwm_peak);
            if (nxt != phase) begin
                phase = nxt;
                phase_start = now;
                elapsed = '0;
            end
            if (phase == hpe_pkg::PH_GAP || phase == hpe_pkg::PH_REST) begin
                len = (phase == hpe_pkg::PH_GAP) ? 32'(gap_len) : rest;
                idle = (elapsed >= len) ? 32'd0 : len - elapsed;
            end else begin
                idle = 32'd1;
            end
            r.rest_entered = (phase == hpe_pkg::PH_REST && seen_before != hpe_pkg::PH_REST);
            seen_before = phase;
            r.duty = duty[15:0];
            r.idle_ms = idle[15:0];
            if (r.rest_entered) rests++;
            duty_owed.push_back(r);
        endfunction

        function int pending();
            return duty_owed.size();
        endfunction

        task flag(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     what, matched, got, want);
        endtask

        task match_envelope(logic [15:0] duty, logic [15:0] idle, logic rest_in);
            t_beat_result w;
            if (duty_owed.size() == 0) begin
                flag("unexpected result", 32'(duty), 32'd0);
                return;
            end
            w = duty_owed.pop_front();
            if (duty !== w.duty) flag("duty", 32'(duty), 32'(w.duty));
            if (idle !== w.idle_ms) flag("idle_ms", 32'(idle), 32'(w.idle_ms));
            if (rest_in !== w.rest_entered) flag("rest_entered", 32'(rest_in),
                                                 32'(w.rest_entered));
            matched++;
        endtask

        task close_out();
            if (duty_owed.size() != 0)
                flag("results never delivered", 32'(duty_owed.size()), 32'd0);
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [hpe_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [hpe_pkg::CFG_DATA_W-1:0] i_cfg_data;

    hpe_in_if  in_ch ();
    hpe_out_if out_ch ();

    t_beat_board board;
    int          sent = 0;
    int          got = 0;
    int          settings = 0;
    int          quiet_cycles = 0;

    heartbeat_pwm_envelope dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #10 i_clk = ~i_clk;

    task automatic offer_tick(input logic [31:0] now,
                              input logic [hpe_pkg::SCORE_W-1:0] score);
        int unsigned gap;
        gap = ((sent / 80) % 5 == 4) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.now_ms <= now;
        in_ch.motion_score <= score;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.log_tick(now, score);
        sent++;
    endtask

    // waits for the block to drain, then writes all six registers back to back
    task automatic set_envelope(input logic [15:0] peak, input logic [15:0] lub,
                                input logic [15:0] gap, input logic [15:0] dub,
                                input logic [15:0] slowest, input logic [15:0] span);
        logic [hpe_pkg::CFG_IDX_W-1:0]  idxs [6];
        logic [hpe_pkg::CFG_DATA_W-1:0] vals [6];
        idxs[0] = hpe_pkg::CFG_PWM_PEAK;     vals[0] = peak;
        idxs[1] = hpe_pkg::CFG_LUB_RAMP;     vals[1] = lub;
        idxs[2] = hpe_pkg::CFG_GAP;          vals[2] = gap;
        idxs[3] = hpe_pkg::CFG_DUB_RAMP;     vals[3] = dub;
        idxs[4] = hpe_pkg::CFG_REST_SLOWEST; vals[4] = slowest;
        idxs[5] = hpe_pkg::CFG_REST_SPAN;    vals[5] = span;
        in_ch.valid <= 1'b0;
        while (board.pending() != 0 || in_ch.ready !== 1'b1) @(posedge i_clk);
        for (int k = 0; k < 6; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idxs[k];
            i_cfg_data <= vals[k];
            board.write_reg(idxs[k], vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [9:0] pick_len();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 10'd0;
        if (k == 1) return 10'd1023;
        return 10'($urandom_range(1, 24));
    endfunction

    initial begin
        logic [31:0]                 now;
        logic [hpe_pkg::SCORE_W-1:0] score;
        int unsigned                 step_max;
        int unsigned                 r;
        logic [9:0]                  l_lub;
        logic [9:0]                  l_gap;
        logic [9:0]                  l_dub;
        logic [15:0]                 peak;
        logic [15:0]                 slowest;
        logic [15:0]                 span;
        board = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= hpe_pkg::CFG_PWM_PEAK;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.now_ms <= '0;
        in_ch.motion_score <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one full beat at the reset settings, then rest cut to zero by a high score
        offer_tick(32'd0, 7'd0);
        offer_tick(32'd20, 7'd0);
        offer_tick(32'd39, 7'd0);
        offer_tick(32'd40, 7'd0);
        offer_tick(32'd60, 7'd0);
        offer_tick(32'd80, 7'd0);
        offer_tick(32'd130, 7'd0);
        offer_tick(32'd160, 7'd0);
        offer_tick(32'd200, 7'd0);
        offer_tick(32'd240, 7'd0);
        offer_tick(32'd319, 7'd0);
        offer_tick(32'd320, 7'd100);
        offer_tick(32'd400, 7'd100);
        offer_tick(32'd401, 7'd127);
        offer_tick(32'd401, 7'd0);

        // widest values in every register but the rest span, and a time stamp that wraps
        set_envelope(16'hFFFF, 16'h03FF, 16'h03FF, 16'h03FF, 16'hFFFF, 16'h0000);
        offer_tick(32'hFFFF_FF00, 7'd0);
        offer_tick(32'hFFFF_FFFF, 7'd0);
        offer_tick(32'h0000_02FF, 7'd0);
        offer_tick(32'h0000_06FF, 7'd0);
        offer_tick(32'h0000_0AFE, 7'd0);
        offer_tick(32'h0000_0CFD, 7'd0);

        // zero-length phases and a peak whose half is zero
        set_envelope(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        offer_tick(32'h0000_0D00, 7'd0);
        offer_tick(32'h0000_0D00, 7'd55);
        offer_tick(32'h0000_0D01, 7'd0);
        offer_tick(32'h0000_0D01, 7'd127);

        now = 32'h0000_0E00;
        for (int p = 0; p < 8; p++) begin
            case (p)
                1: begin
                    set_envelope(16'hFFFF, 16'hFFFF, 16'hFC00 | 16'h03FF, 16'h03FF,
                                 16'hFFFF, 16'hFFFF);
                    step_max = 343;
                end
                2: begin
                    set_envelope(16'd1, 16'hFC01, 16'd1, 16'd1, 16'd0, 16'd0);
                    step_max = 2;
                end
                7: begin
                    set_envelope(hpe_pkg::PWM_PEAK_RST, 16'(hpe_pkg::LUB_RAMP_RST),
                                 16'(hpe_pkg::GAP_RST), 16'(hpe_pkg::DUB_RAMP_RST),
                                 hpe_pkg::REST_SLOWEST_RST, hpe_pkg::REST_SPAN_RST);
                    step_max = 30;
                end
                default: begin
                    l_lub = pick_len();
                    l_gap = pick_len();
                    l_dub = pick_len();
                    r = $urandom_range(0, 3);
                    peak = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF :
                           (r == 2) ? 16'($urandom()) : 16'($urandom_range(2, 600));
                    slowest = ($urandom_range(0, 9) == 0) ? 16'hFFFF :
                              16'($urandom_range(0, 150));
                    span = ($urandom_range(0, 1) == 0) ? 16'($urandom()) :
                           16'($urandom_range(0, 300));
                    // upper data bits above a 10-bit register are dropped
                    set_envelope(peak, {6'($urandom()), l_lub}, {6'($urandom()), l_gap},
                                 {6'($urandom()), l_dub}, slowest, span);
                    step_max = 32'(l_lub);
                    if (32'(l_gap) > step_max) step_max = 32'(l_gap);
                    if (32'(l_dub) > step_max) step_max = 32'(l_dub);
                    step_max = step_max / 3 + 2;
                end
            endcase
            repeat (190) begin
                r = $urandom_range(0, 99);
                if (r < 2) now = $urandom();
                else if (r < 10) now = now + $urandom_range(0, 70000);
                else now = now + $urandom_range(0, step_max);
                score = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127)) :
                        7'($urandom_range(0, 100));
                offer_tick(now, score);
            end
        end

        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        board.close_out();
        $display("run covered %0d items and %0d results over %0d register settings",
                 sent, got, settings);
        $display("rest entered %0d times, with wrapped time stamps and scores past 100",
                 board.rests);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random stalls, two long hold-offs that back the block up
    initial begin
        int unsigned hold;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (got == 250 || got == 1100) hold = 600;
            else hold = ((got / 70) % 4 == 3) ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            board.match_envelope(out_ch.duty, out_ch.idle_ms, out_ch.rest_entered);
            got++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

>>> files.f
+incdir+sv
sv/hpe_pkg.sv
sv/hpe_in_if.sv
sv/hpe_out_if.sv
sv/hpe_cfg.sv
sv/hpe_div.sv
sv/heartbeat_pwm_envelope.sv
tb/heartbeat_pwm_envelope_test.sv
